// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Defining SYNTH removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Assertion clocked on clk, disabled while the active-low reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);
// Assertion clocked on clk that is checked during reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/euf_pkg.sv =====
// ----------------------------------------------------------------------------
// euf_pkg
// Types and constants shared by the escaped frame encoder modules.
// ----------------------------------------------------------------------------
package euf_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ESCAPE = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_END    = 2'd2;

    localparam logic [7:0] ESCAPE_RESET = 8'd253;
    localparam logic [7:0] START_RESET  = 8'd255;
    localparam logic [7:0] END_RESET    = 8'd254;

    // Output slots of one request, in emission order.
    localparam int SLOT_START  = 0;
    localparam int SLOT_AH_ESC = 1;
    localparam int SLOT_AH     = 2;
    localparam int SLOT_AL_ESC = 3;
    localparam int SLOT_AL     = 4;
    localparam int SLOT_D_ESC  = 5;
    localparam int SLOT_D      = 6;
    localparam int SLOT_END    = 7;
    localparam int NUM_SLOTS   = 8;

    typedef struct packed {
        logic [7:0] escape_value;
        logic [7:0] start_value;
        logic [7:0] end_value;
    } cfg_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [15:0]          dest_addr;
        logic [7:0]           data_byte;
    } desc_t;

endpackage

// ===== rtl/core/euf_front.sv =====
// ----------------------------------------------------------------------------
// euf_front
// Accepts input requests and turns each into a slot mask for the back end.
// ----------------------------------------------------------------------------
module euf_front (
    input  euf_pkg::cfg_t  cfg,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [15:0]    s_dest_addr,
    input  logic [7:0]     s_data_byte,
    input  logic           s_has_byte,
    input  logic           s_first,
    input  logic           s_last,
    input  logic           q_full,
    output logic           q_push,
    output euf_pkg::desc_t q_desc
);

    logic ah_esc;
    logic al_esc;
    logic d_esc;
    logic [euf_pkg::NUM_SLOTS-1:0] mask;

    assign ah_esc = s_dest_addr[15:8] >= cfg.escape_value;
    assign al_esc = s_dest_addr[7:0] >= cfg.escape_value;
    assign d_esc  = s_data_byte >= cfg.escape_value;

    always_comb begin
        mask                         = '0;
        mask[euf_pkg::SLOT_START]    = s_first;
        mask[euf_pkg::SLOT_AH_ESC]   = s_first & ah_esc;
        mask[euf_pkg::SLOT_AH]       = s_first;
        mask[euf_pkg::SLOT_AL_ESC]   = s_first & al_esc;
        mask[euf_pkg::SLOT_AL]       = s_first;
        mask[euf_pkg::SLOT_D_ESC]    = s_has_byte & d_esc;
        mask[euf_pkg::SLOT_D]        = s_has_byte;
        mask[euf_pkg::SLOT_END]      = s_last;
    end

    // A request that produces no bytes is accepted and dropped here.
    assign s_ready          = !q_full;
    assign q_push           = s_valid && s_ready && (mask != '0);
    assign q_desc.mask      = mask;
    assign q_desc.dest_addr = s_dest_addr;
    assign q_desc.data_byte = s_data_byte;

endmodule

// ===== rtl/core/euf_queue.sv =====
// ----------------------------------------------------------------------------
// euf_queue
// Small first-in first-out queue of request descriptors.
// ----------------------------------------------------------------------------
module euf_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  euf_pkg::desc_t push_desc,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output euf_pkg::desc_t head_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    euf_pkg::desc_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_desc  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== rtl/core/euf_back.sv =====
// ----------------------------------------------------------------------------
// euf_back
// Walks the slots of the head descriptor, one output byte per cycle unless m_ready stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euf_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  euf_pkg::cfg_t  cfg,
    input  logic           head_valid,
    input  euf_pkg::desc_t head_desc,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_run_last,
    output logic           m_frame_done,
    output logic [15:0]    m_frame_bytes
);

    localparam int NS = euf_pkg::NUM_SLOTS;

    logic [NS-1:0] done_mask_reg;
    logic [NS-1:0] done_mask_next;
    logic [15:0]   count_reg;
    logic [15:0]   count_next;
    logic          m_valid_reg;
    logic [7:0]    m_out_byte_reg;
    logic          m_run_last_reg;
    logic          m_frame_done_reg;
    logic [15:0]   m_frame_bytes_reg;

    logic [NS-1:0] remaining;
    logic [NS-1:0] slot_bit;
    logic          advance;
    logic          fire;
    logic          last_slot;
    logic [15:0]   count_inc;
    logic [7:0]    addr_hi;
    logic [7:0]    addr_lo;
    logic [7:0]    byte_sel;

    assign remaining = head_desc.mask & ~done_mask_reg;
    assign slot_bit  = remaining & (~remaining + NS'(1));
    assign advance   = !m_valid_reg || m_ready;
    assign fire      = head_valid && advance;
    assign last_slot = remaining == slot_bit;
    assign pop       = fire && last_slot;
    assign count_inc = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;
    assign addr_hi   = head_desc.dest_addr[15:8];
    assign addr_lo   = head_desc.dest_addr[7:0];

    // Escape slots emit the escape byte; the byte slot after one carries the XOR.
    always_comb begin
        if (slot_bit[euf_pkg::SLOT_START]) begin
            byte_sel = cfg.start_value;
        end else if (slot_bit[euf_pkg::SLOT_AH]) begin
            byte_sel = head_desc.mask[euf_pkg::SLOT_AH_ESC] ?
                       (addr_hi ^ cfg.escape_value) : addr_hi;
        end else if (slot_bit[euf_pkg::SLOT_AL]) begin
            byte_sel = head_desc.mask[euf_pkg::SLOT_AL_ESC] ?
                       (addr_lo ^ cfg.escape_value) : addr_lo;
        end else if (slot_bit[euf_pkg::SLOT_D]) begin
            byte_sel = head_desc.mask[euf_pkg::SLOT_D_ESC] ?
                       (head_desc.data_byte ^ cfg.escape_value) : head_desc.data_byte;
        end else if (slot_bit[euf_pkg::SLOT_END]) begin
            byte_sel = cfg.end_value;
        end else begin
            byte_sel = cfg.escape_value;
        end
    end

    always_comb begin
        done_mask_next = done_mask_reg;
        count_next     = count_reg;
        if (fire) begin
            done_mask_next = last_slot ? '0 : (done_mask_reg | slot_bit);
            if (slot_bit[euf_pkg::SLOT_START]) begin
                count_next = 16'd1;
            end else if (slot_bit[euf_pkg::SLOT_END]) begin
                count_next = '0;
            end else begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_mask_reg <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            done_mask_reg <= done_mask_next;
            count_reg     <= count_next;
            if (advance) begin
                m_valid_reg <= head_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_out_byte_reg    <= byte_sel;
            m_run_last_reg    <= last_slot;
            m_frame_done_reg  <= slot_bit[euf_pkg::SLOT_END];
            m_frame_bytes_reg <= slot_bit[euf_pkg::SLOT_END] ? count_inc : 16'd0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_run_last    = m_run_last_reg;
    assign m_frame_done  = m_frame_done_reg;
    assign m_frame_bytes = m_frame_bytes_reg;

    `ASSERT_CLK_RST(a_one_slot, aclk, aresetn, fire |-> $onehot(slot_bit), "no single slot chosen")
    `ASSERT_CLK_RST(a_end_closes, aclk, aresetn, (m_valid_reg && m_frame_done_reg) |-> m_run_last_reg, "end byte not last of request")
    `ASSERT_CLK_RST(a_bytes_only_end, aclk, aresetn, (m_valid_reg && !m_frame_done_reg) |-> (m_frame_bytes_reg == 16'd0), "frame count outside end byte")
    `ASSERT_CLK_RST(a_start_count, aclk, aresetn, (fire && slot_bit[euf_pkg::SLOT_START]) |=> (count_reg == 16'd1), "count not restarted by start byte")

endmodule

// ===== rtl/core/escaped_uart_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// escaped_uart_frame_encoder
// Byte-stuffing frame encoder: start byte, escaped address and payload,
// end byte with a saturating frame byte count.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s_*     | in  | s_valid / s_ready | dest_addr, data_byte, has_byte, first, last
//  m_*     | out | m_valid / m_ready | out_byte, run_last, frame_done, frame_bytes
//  apb     | in  | psel / penable    | paddr, pwdata, prdata (3 registers)
//
// One output byte leaves per cycle unless m_ready stalls the output; a request
// produces up to 8 bytes, a plain payload byte 1 or 2. A request that
// produces nothing is accepted and never enters the queue.
// The back-end byte sequencer sets this rate; the queue holds QUEUE_DEPTH
// requests, including the one being sent.
// Reset is synchronous and active low; it restores the register defaults and
// empties the queue. Either side may stall without stalling the other until
// the queue fills.
// ----------------------------------------------------------------------------
module escaped_uart_frame_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_dest_addr,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_first,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_frame_done,
    output logic [15:0] m_frame_bytes
);

    euf_pkg::cfg_t  cfg_reg;
    euf_pkg::desc_t q_desc;
    euf_pkg::desc_t head_desc;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           head_valid;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.escape_value <= euf_pkg::ESCAPE_RESET;
            cfg_reg.start_value  <= euf_pkg::START_RESET;
            cfg_reg.end_value    <= euf_pkg::END_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                euf_pkg::REG_ESCAPE: cfg_reg.escape_value <= pwdata[7:0];
                euf_pkg::REG_START:  cfg_reg.start_value  <= pwdata[7:0];
                euf_pkg::REG_END:    cfg_reg.end_value    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            euf_pkg::REG_ESCAPE: prdata = {24'd0, cfg_reg.escape_value};
            euf_pkg::REG_START:  prdata = {24'd0, cfg_reg.start_value};
            euf_pkg::REG_END:    prdata = {24'd0, cfg_reg.end_value};
            default:             prdata = '0;
        endcase
    end

    euf_front u_front (
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_dest_addr (s_dest_addr),
        .s_data_byte (s_data_byte),
        .s_has_byte  (s_has_byte),
        .s_first     (s_first),
        .s_last      (s_last),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_desc      (q_desc)
    );

    euf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    euf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .head_valid    (head_valid),
        .head_desc     (head_desc),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_frame_done  (m_frame_done),
        .m_frame_bytes (m_frame_bytes)
    );

endmodule
